/* rtl/framebuffer_line_rect_drawer_unit_assert.svh */
// Assertion helpers shared by the drawer modules.
// Each macro expects signals named clock and reset in the module that uses it.
`ifndef FRAMEBUFFER_LINE_RECT_DRAWER_UNIT_ASSERT_SVH
`define FRAMEBUFFER_LINE_RECT_DRAWER_UNIT_ASSERT_SVH

// Same-cycle implication.
`define FRLD_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define FRLD_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/frld_pkg.sv */
package frld_pkg;

   // Panel geometry and store size.
   localparam int PANEL_WIDTH = 128;
   localparam int MAX_HEIGHT  = 64;
   localparam int PAGE_ROWS   = 8;
   localparam int STORE_DEPTH = PANEL_WIDTH * ((MAX_HEIGHT + PAGE_ROWS - 1) / PAGE_ROWS);
   localparam int ADDR_W      = $clog2(STORE_DEPTH);

   // Field widths of the channels.
   localparam int REQ_W       = 3;
   localparam int COORD_IN_W  = 8;
   localparam int BYTE_ADDR_W = 10;
   localparam int DATA_W      = 8;

   // Internal coordinate widths: rectangle ends reach twice the input range.
   localparam int CRD_W = COORD_IN_W + 1;
   localparam int ROT_W = CRD_W + 2;
   localparam int ERR_W = CRD_W + 3;

   // Configuration port.
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 7;
   localparam int HGT_W      = 7;
   localparam int ROTN_W     = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_ROTATION     = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PANEL_HEIGHT = 1'd1;

   localparam logic [HGT_W-1:0] PANEL_HEIGHT_RESET = 7'd64;

   // Request codes.
   localparam logic [REQ_W-1:0] REQ_PIXEL = 3'd0;
   localparam logic [REQ_W-1:0] REQ_LINE  = 3'd1;
   localparam logic [REQ_W-1:0] REQ_RECT  = 3'd2;
   localparam logic [REQ_W-1:0] REQ_FILL  = 3'd3;
   localparam logic [REQ_W-1:0] REQ_READ  = 3'd4;

   // Rotation codes in quarter turns.
   localparam logic [ROTN_W-1:0] ROT_0   = 2'd0;
   localparam logic [ROTN_W-1:0] ROT_90  = 2'd1;
   localparam logic [ROTN_W-1:0] ROT_180 = 2'd2;
   localparam logic [ROTN_W-1:0] ROT_270 = 2'd3;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load_item;
      logic row_setup;
      logic line_step;
      logic pixel_emit;
      logic clear_step;
      logic fill_step;
      logic read_issue;
      logic rsp_load;
   } frld_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic line_done;
      logic rows_done;
      logic clear_last;
      logic fill_last;
      logic fill_empty;
   } frld_sts_type;

endpackage

/* rtl/frld_req_if.sv */
interface frld_req_if;
   import frld_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [REQ_W-1:0]       req_type;
   logic [COORD_IN_W-1:0]  x0;
   logic [COORD_IN_W-1:0]  y0;
   logic [COORD_IN_W-1:0]  x1;
   logic [COORD_IN_W-1:0]  y1;
   logic [COORD_IN_W-1:0]  rect_width;
   logic [COORD_IN_W-1:0]  rect_height;
   logic                   pixel_on;
   logic [DATA_W-1:0]      fill_byte;
   logic [BYTE_ADDR_W-1:0] byte_addr;

   modport source (
      output valid, req_type, x0, y0, x1, y1, rect_width, rect_height,
             pixel_on, fill_byte, byte_addr,
      input  ready
   );

   modport sink (
      input  valid, req_type, x0, y0, x1, y1, rect_width, rect_height,
             pixel_on, fill_byte, byte_addr,
      output ready
   );
endinterface

/* rtl/frld_rsp_if.sv */
interface frld_rsp_if;
   import frld_pkg::*;

   logic              valid;
   logic              ready;
   logic [DATA_W-1:0] read_data;
   logic              is_read;

   modport source (output valid, read_data, is_read, input ready);
   modport sink (input valid, read_data, is_read, output ready);
endinterface

/* rtl/framebuffer_line_rect_drawer_unit.sv */
// Drawing engine for a page-organised monochrome framebuffer of 128 x 64 pixels (1024 bytes,
// eight vertical pixels per byte). Each request sets or clears a pixel, draws a line that
// stops short of its end point, fills a rectangle row by row, fills all active bytes, or
// reads one byte back, and returns exactly one result item. Pixels are rotated by the
// configured quarter turns and dropped when they land off the panel. Work is done one item
// at a time, and no new request is accepted until the result of the last one has been loaded;
// the pixel rate is set by the single read-modify-write port of the frame store, which
// handles one pixel per cycle with back-to-back updates to the same byte forwarded. After
// reset the whole store is cleared, during which no item is accepted; configuration writes
// are taken at any time and should be made while the block is idle.
module framebuffer_line_rect_drawer_unit (
   input  logic                            clock,
   input  logic                            reset,
   frld_req_if.sink                        req_if,
   frld_rsp_if.source                      rsp_if,
   input  logic                            csr_we,
   input  logic [frld_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [frld_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import frld_pkg::*;

   frld_cmd_type cmd;
   frld_sts_type sts;

   // Sequencer.
   frld_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_type  (req_if.req_type),
      .req_ready (req_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   // Stepper, pixel pipeline and frame store.
   frld_dp u_dp (
      .clock         (clock),
      .reset         (reset),
      .req_type      (req_if.req_type),
      .x0            (req_if.x0),
      .y0            (req_if.y0),
      .x1            (req_if.x1),
      .y1            (req_if.y1),
      .rect_width    (req_if.rect_width),
      .rect_height   (req_if.rect_height),
      .pixel_on      (req_if.pixel_on),
      .fill_byte     (req_if.fill_byte),
      .byte_addr     (req_if.byte_addr),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .cmd           (cmd),
      .sts           (sts),
      .rsp_read_data (rsp_if.read_data),
      .rsp_is_read   (rsp_if.is_read)
   );

endmodule

/* rtl/frld_ctrl.sv */
`include "framebuffer_line_rect_drawer_unit_assert.svh"

module frld_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic [frld_pkg::REQ_W-1:0] req_type,
   output logic                      req_ready,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output frld_pkg::frld_cmd_type    cmd,
   input  frld_pkg::frld_sts_type    sts
);
   import frld_pkg::*;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_PIXEL,
      ST_LINE,
      ST_ROW,
      ST_FILL,
      ST_READ,
      ST_FINISH
   } state_type;

   state_type state_ff, state_in;
   logic      rect_ff, rect_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   // Next state and command decode.
   always_comb begin
      out_free     = !rsp_valid_ff || rsp_ready;
      cmd          = '0;
      state_in     = state_ff;
      rect_in      = rect_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (sts.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_item = 1'b1;
               rect_in       = (req_type == REQ_RECT);
               case (req_type)
                  REQ_PIXEL: state_in = ST_PIXEL;
                  REQ_LINE:  state_in = ST_LINE;
                  REQ_RECT:  state_in = ST_ROW;
                  REQ_FILL:  state_in = ST_FILL;
                  REQ_READ:  state_in = ST_READ;
                  default:   state_in = ST_FINISH;
               endcase
            end
         end
         ST_PIXEL: begin
            cmd.pixel_emit = 1'b1;
            state_in       = ST_FINISH;
         end
         ST_LINE: begin
            if (sts.line_done) begin
               state_in = rect_ff ? ST_ROW : ST_FINISH;
            end else begin
               cmd.line_step = 1'b1;
            end
         end
         ST_ROW: begin
            if (sts.rows_done) begin
               state_in = ST_FINISH;
            end else begin
               cmd.row_setup = 1'b1;
               state_in      = ST_LINE;
            end
         end
         ST_FILL: begin
            if (sts.fill_empty) begin
               state_in = ST_FINISH;
            end else begin
               cmd.fill_step = 1'b1;
               if (sts.fill_last) begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_READ: begin
            cmd.read_issue = 1'b1;
            state_in       = ST_FINISH;
         end
         ST_FINISH: begin
            if (out_free) begin
               cmd.rsp_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rect_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rect_ff      <= rect_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   `FRLD_ASSERT_IMP(a_rsp_no_overwrite, cmd.rsp_load, !rsp_valid_ff || rsp_ready, "result overwritten")
   `FRLD_ASSERT_NXT(a_accept_leaves_idle, req_valid && req_ready, state_ff != ST_IDLE, "stayed idle after accept")
   `FRLD_ASSERT_IMP(a_no_rsp_in_clear, state_ff == ST_CLEAR, !rsp_valid_ff, "result during clearing pass")

endmodule

/* rtl/frld_dp.sv */
`include "framebuffer_line_rect_drawer_unit_assert.svh"

module frld_dp (
   input  logic                             clock,
   input  logic                             reset,
   input  logic [frld_pkg::REQ_W-1:0]       req_type,
   input  logic [frld_pkg::COORD_IN_W-1:0]  x0,
   input  logic [frld_pkg::COORD_IN_W-1:0]  y0,
   input  logic [frld_pkg::COORD_IN_W-1:0]  x1,
   input  logic [frld_pkg::COORD_IN_W-1:0]  y1,
   input  logic [frld_pkg::COORD_IN_W-1:0]  rect_width,
   input  logic [frld_pkg::COORD_IN_W-1:0]  rect_height,
   input  logic                             pixel_on,
   input  logic [frld_pkg::DATA_W-1:0]      fill_byte,
   input  logic [frld_pkg::BYTE_ADDR_W-1:0] byte_addr,
   input  logic                             csr_we,
   input  logic [frld_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [frld_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  frld_pkg::frld_cmd_type           cmd,
   output frld_pkg::frld_sts_type           sts,
   output logic [frld_pkg::DATA_W-1:0]      rsp_read_data,
   output logic                             rsp_is_read
);
   import frld_pkg::*;

   // Configuration.
   logic [ROTN_W-1:0] rotation_ff;
   logic [HGT_W-1:0]  panel_height_ff;
   logic [HGT_W-1:0]  eff_h;

   // Latched item.
   logic                   on_ff;
   logic [DATA_W-1:0]      fill_ff;
   logic [BYTE_ADDR_W-1:0] byte_addr_ff;
   logic                   is_read_ff;
   logic [CRD_W-1:0]       rect_x0_ff, rect_xend_ff, row_ff, row_end_ff;

   // Line stepper.
   logic [CRD_W-1:0]        cx_ff, cy_ff, ex_ff, ey_ff, dx_ff, dy_ff;
   logic                    stx_neg_ff, sty_neg_ff, xmaj_ff;
   logic signed [ERR_W-1:0] err_ff;

   logic [CRD_W-1:0]        ln_sx, ln_sy, ln_ex, ln_ey, ln_dx, ln_dy;
   logic signed [CRD_W:0]   ln_dxr, ln_dyr;
   logic                    ln_xmaj;
   logic signed [ERR_W-1:0] ln_err, ln_2dx, ln_2dy;

   logic [CRD_W-1:0]        st_cx, st_cy, st_cx_mv, st_cy_mv;
   logic signed [ERR_W-1:0] st_err, st_2dx, st_2dy;
   logic                    err_nonneg;

   // Pixel pipeline.
   logic                    emit;
   logic signed [ROT_W-1:0] px_s, py_s, w1_s, h1_s, h_s, w_s, rx, ry;
   logic                    pix_ok;
   logic [ADDR_W-1:0]       pix_idx;
   logic [2:0]              pix_bit;
   logic                    s1_valid_ff;
   logic [ADDR_W-1:0]       s1_idx_ff;
   logic [2:0]              s1_bit_ff;
   logic                    fwd_valid_ff;
   logic [ADDR_W-1:0]       fwd_idx_ff;
   logic [DATA_W-1:0]       fwd_data_ff;
   logic [DATA_W-1:0]       merge_base, merge_mask, merge_byte;

   // Store and sweep.
   logic [DATA_W-1:0]   frame_mem_ff [STORE_DEPTH];
   logic [DATA_W-1:0]   rd_data_ff;
   logic                rd_en, wr_en, sweep_we;
   logic [ADDR_W-1:0]   rd_addr, wr_addr;
   logic [DATA_W-1:0]   wr_data;
   logic [ADDR_W-1:0]   sweep_ff;
   logic [ADDR_W:0]     fill_cnt;
   logic                rd_in_range;

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         rotation_ff     <= ROT_0;
         panel_height_ff <= PANEL_HEIGHT_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_ROTATION:     rotation_ff     <= csr_wdata[ROTN_W-1:0];
            CSR_PANEL_HEIGHT: panel_height_ff <= csr_wdata[HGT_W-1:0];
            default: ;
         endcase
      end
   end

   // Usable height: limited to the panel maximum and rounded down to whole pages.
   always_comb begin
      eff_h = (panel_height_ff > HGT_W'(MAX_HEIGHT)) ? HGT_W'(MAX_HEIGHT) : panel_height_ff;
      eff_h = eff_h & ~HGT_W'(PAGE_ROWS - 1);
   end

   // Line setup from the request or from the current rectangle row.
   always_comb begin
      if (cmd.row_setup) begin
         ln_sx = rect_x0_ff;
         ln_sy = row_ff;
         ln_ex = rect_xend_ff;
         ln_ey = row_ff;
      end else begin
         ln_sx = CRD_W'(x0);
         ln_sy = CRD_W'(y0);
         ln_ex = CRD_W'(x1);
         ln_ey = CRD_W'(y1);
      end
      ln_dxr  = $signed({1'b0, ln_ex}) - $signed({1'b0, ln_sx});
      ln_dyr  = $signed({1'b0, ln_ey}) - $signed({1'b0, ln_sy});
      ln_dx   = ln_dxr[CRD_W] ? CRD_W'(-ln_dxr) : CRD_W'(ln_dxr);
      ln_dy   = ln_dyr[CRD_W] ? CRD_W'(-ln_dyr) : CRD_W'(ln_dyr);
      ln_xmaj = (ln_dx >= ln_dy);
      ln_2dx  = $signed(ERR_W'({ln_dx, 1'b0}));
      ln_2dy  = $signed(ERR_W'({ln_dy, 1'b0}));
      ln_err  = ln_xmaj ? (ln_2dy - $signed(ERR_W'(ln_dx)))
                        : (ln_2dx - $signed(ERR_W'(ln_dy)));
   end

   // One Bresenham step.
   always_comb begin
      err_nonneg = !err_ff[ERR_W-1];
      st_2dx     = $signed(ERR_W'({dx_ff, 1'b0}));
      st_2dy     = $signed(ERR_W'({dy_ff, 1'b0}));
      st_cx_mv   = stx_neg_ff ? (cx_ff - CRD_W'(1)) : (cx_ff + CRD_W'(1));
      st_cy_mv   = sty_neg_ff ? (cy_ff - CRD_W'(1)) : (cy_ff + CRD_W'(1));
      if (xmaj_ff) begin
         st_cx  = st_cx_mv;
         st_cy  = err_nonneg ? st_cy_mv : cy_ff;
         st_err = err_ff - (err_nonneg ? st_2dx : ERR_W'(0)) + st_2dy;
      end else begin
         st_cy  = st_cy_mv;
         st_cx  = err_nonneg ? st_cx_mv : cx_ff;
         st_err = err_ff - (err_nonneg ? st_2dy : ERR_W'(0)) + st_2dx;
      end
   end

   // Item latch, rectangle rows and line stepper registers.
   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         on_ff        <= pixel_on;
         fill_ff      <= fill_byte;
         byte_addr_ff <= byte_addr;
         is_read_ff   <= (req_type == REQ_READ);
         rect_x0_ff   <= CRD_W'(x0);
         rect_xend_ff <= CRD_W'(x0) + CRD_W'(rect_width);
         row_ff       <= CRD_W'(y0);
         row_end_ff   <= CRD_W'(y0) + CRD_W'(rect_height);
      end else if (cmd.row_setup) begin
         row_ff <= row_ff + CRD_W'(1);
      end
      if (cmd.load_item || cmd.row_setup) begin
         cx_ff      <= ln_sx;
         cy_ff      <= ln_sy;
         ex_ff      <= ln_ex;
         ey_ff      <= ln_ey;
         dx_ff      <= ln_dx;
         dy_ff      <= ln_dy;
         stx_neg_ff <= (ln_dxr <= 0);
         sty_neg_ff <= (ln_dyr <= 0);
         xmaj_ff    <= ln_xmaj;
         err_ff     <= ln_err;
      end else if (cmd.line_step) begin
         cx_ff  <= st_cx;
         cy_ff  <= st_cy;
         err_ff <= st_err;
      end
   end

   // Rotate the pixel, clip it to the panel and form its byte address.
   always_comb begin
      emit = cmd.line_step || cmd.pixel_emit;
      px_s = $signed(ROT_W'(cx_ff));
      py_s = $signed(ROT_W'(cy_ff));
      w_s  = $signed(ROT_W'(PANEL_WIDTH));
      h_s  = $signed(ROT_W'(eff_h));
      w1_s = w_s - $signed(ROT_W'(1));
      h1_s = h_s - $signed(ROT_W'(1));
      case (rotation_ff)
         ROT_90: begin
            rx = w1_s - py_s;
            ry = px_s;
         end
         ROT_180: begin
            rx = w1_s - px_s;
            ry = h1_s - py_s;
         end
         ROT_270: begin
            rx = py_s;
            ry = h1_s - px_s;
         end
         default: begin
            rx = px_s;
            ry = py_s;
         end
      endcase
      pix_ok  = !rx[ROT_W-1] && (rx < w_s) && !ry[ROT_W-1] && (ry < h_s);
      pix_idx = ADDR_W'(rx[ROT_W-2:0]) + ADDR_W'((ry[ROT_W-2:0] >> 3) * PANEL_WIDTH);
      pix_bit = ry[2:0];
   end

   // Modify stage: take the byte just written if the address repeats.
   always_comb begin
      merge_base = (fwd_valid_ff && (fwd_idx_ff == s1_idx_ff)) ? fwd_data_ff : rd_data_ff;
      merge_mask = DATA_W'(1) << s1_bit_ff;
      merge_byte = on_ff ? (merge_base | merge_mask) : (merge_base & ~merge_mask);
   end

   // Pipeline control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         fwd_valid_ff <= 1'b0;
         sweep_ff     <= '0;
      end else begin
         s1_valid_ff  <= emit && pix_ok;
         fwd_valid_ff <= s1_valid_ff;
         if (cmd.load_item) begin
            sweep_ff <= '0;
         end else if (sweep_we) begin
            sweep_ff <= sweep_ff + ADDR_W'(1);
         end
      end
   end

   // Pipeline payload registers.
   always_ff @(posedge clock) begin
      s1_idx_ff <= pix_idx;
      s1_bit_ff <= pix_bit;
      if (s1_valid_ff) begin
         fwd_idx_ff  <= s1_idx_ff;
         fwd_data_ff <= merge_byte;
      end
   end

   // Store port selection.
   always_comb begin
      sweep_we = cmd.clear_step || cmd.fill_step;
      rd_en    = emit || cmd.read_issue;
      rd_addr  = cmd.read_issue ? ADDR_W'(byte_addr_ff) : pix_idx;
      wr_en    = sweep_we || s1_valid_ff;
      wr_addr  = sweep_we ? sweep_ff : s1_idx_ff;
      if (cmd.clear_step) begin
         wr_data = '0;
      end else if (cmd.fill_step) begin
         wr_data = fill_ff;
      end else begin
         wr_data = merge_byte;
      end
   end

   // Frame store: one write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         frame_mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= frame_mem_ff[rd_addr];
      end
   end

   // Result payload.
   assign rd_in_range = (BYTE_ADDR_W+1)'(byte_addr_ff) < (BYTE_ADDR_W+1)'(STORE_DEPTH);

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_read_data <= (is_read_ff && rd_in_range) ? rd_data_ff : '0;
         rsp_is_read   <= is_read_ff;
      end
   end

   // Status back to the controller.
   always_comb begin
      fill_cnt       = (ADDR_W+1)'((eff_h >> 3) * PANEL_WIDTH);
      sts.line_done  = xmaj_ff ? (cx_ff == ex_ff) : (cy_ff == ey_ff);
      sts.rows_done  = (row_ff == row_end_ff);
      sts.clear_last = (sweep_ff == ADDR_W'(STORE_DEPTH - 1));
      sts.fill_empty = (fill_cnt == '0);
      sts.fill_last  = ({1'b0, sweep_ff} == (fill_cnt - (ADDR_W+1)'(1)));
   end

   `FRLD_ASSERT_IMP(a_sweep_no_pixel, cmd.clear_step || cmd.fill_step, !s1_valid_ff, "sweep collides with pixel write")
   `FRLD_ASSERT_IMP(a_read_no_emit, cmd.read_issue, !emit, "byte read collides with pixel read")
   `FRLD_ASSERT_IMP(a_item_drained, cmd.load_item, !s1_valid_ff, "new item while pixel write pending")

endmodule
